// ===== hdl/periodic_timer_catchup_top_assert.svh =====
// assertion macros shared by the timer rtl
`ifndef PERIODIC_TIMER_CATCHUP_TOP_ASSERT_SVH
`define PERIODIC_TIMER_CATCHUP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// clocked check with synchronous reset masking
`define PTC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also holds during reset
`define PTC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTC_ASSERT(label, clk, rst, prop, msg)
`define PTC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hdl/ptc_pkg.sv =====
// shared constants, state codes and control types of the periodic timer
`default_nettype none
package ptc_pkg;
   localparam int TIME_BITS = 48;
   localparam int CNT_BITS  = $clog2(TIME_BITS);
   localparam int TICK_BITS = 16;
   localparam int REG_BITS  = 32;
   localparam int OUT_BITS  = 48;
   localparam int IDX_BITS  = 8;

   localparam logic [CNT_BITS-1:0]  CNT_LAST  = CNT_BITS'(TIME_BITS - 1);
   localparam logic [REG_BITS-1:0]  COUNT_MAX = '1;
   localparam logic [TIME_BITS-1:0] TIME_MAX  = '1;

   // register indexes of the csr port
   localparam logic [IDX_BITS-1:0] CSR_INTERVAL = IDX_BITS'(0);
   localparam logic [IDX_BITS-1:0] CSR_DELAY    = IDX_BITS'(1);
   localparam logic [IDX_BITS-1:0] CSR_REPEAT   = IDX_BITS'(2);
   localparam logic [IDX_BITS-1:0] CSR_FOREVER  = IDX_BITS'(3);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD,
      S_ADD_END,
      S_CMP,
      S_CMP_END,
      S_COUNT,
      S_COUNT2,
      S_DIV,
      S_UPD,
      S_UPD_END,
      S_DONE
   } state_type;

   // control of one bit-serial adder
   typedef struct packed {
      logic clear;
      logic init_carry;
      logic enable;
      logic invert_b;
   } adder_ctrl_type;
endpackage
`default_nettype wire

// ===== hdl/periodic_timer_catchup_top.sv =====
// periodic timer with delay, repeat count and catch-up, bit-serial datapath
//
//   channel | ports                          | moves
//   --------+--------------------------------+--------------------------------
//   req     | req_valid/req_ready            | one tick request (tick_ms)
//   rsp     | rsp_valid/rsp_ready            | fired, since_last_ms, armed
//   csr     | csr_valid/csr_ready            | register write (index, data)
//
// each pass over the 48-bit times (add, compare, remainder, update) is one bit a
// cycle; the remainder and update passes run only when a fire needs the catch-up remainder.
// reset is synchronous and re-arms the timer, as does any csr write to a known
// register. one request is worked at a time; a finished response waits in the
// output register, so a stalled rsp side only holds the block at its end.
`default_nettype none
`include "periodic_timer_catchup_top_assert.svh"
module periodic_timer_catchup_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ptc_pkg::TICK_BITS-1:0]  req_tick_ms,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_fired,
   output logic [ptc_pkg::OUT_BITS-1:0]   rsp_since_last_ms,
   output logic                           rsp_armed,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ptc_pkg::IDX_BITS-1:0]   csr_index,
   input  logic [ptc_pkg::REG_BITS-1:0]   csr_data
);
   import ptc_pkg::*;

   state_type state_ff, state_in;

   logic [REG_BITS-1:0]  interval_ff, interval_in;
   logic [REG_BITS-1:0]  delay_ff, delay_in;
   logic [REG_BITS-1:0]  repeat_ff, repeat_in;
   logic                 forever_ff, forever_in;

   logic [TIME_BITS-1:0] rt_ff, rt_in;
   logic [TIME_BITS-1:0] nd_ff, nd_in;
   logic [TIME_BITS-1:0] lf_ff, lf_in;
   logic [TIME_BITS-1:0] dt_ff, dt_in;
   logic [TIME_BITS-1:0] since_ff, since_in;
   logic [TICK_BITS-1:0] tick_ff, tick_in;
   logic [REG_BITS-1:0]  rsub_ff, rsub_in;
   logic [REG_BITS-1:0]  iv_ff, iv_in;
   logic [REG_BITS-1:0]  fc_ff, fc_in;
   logic                 active_ff, active_in;
   logic                 fired_ff, fired_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_fired_ff, rsp_fired_in;
   logic [OUT_BITS-1:0]  rsp_since_ff, rsp_since_in;
   logic                 rsp_armed_ff, rsp_armed_in;

   adder_ctrl_type       ctl_a, ctl_b;
   logic                 a_a, b_a, sum_a, carry_a;
   logic                 a_b, b_b, sum_b, carry_b;
   logic                 div_start, div_done;
   logic [REG_BITS-1:0]  div_rem;

   logic                 csr_write, csr_hit;
   logic [REG_BITS-1:0]  interval_new, delay_new;
   logic [TIME_BITS-1:0] arm_due;
   logic                 pass_last;

   // serial adders, shared between the passes
   ptc_bit_adder u_adder_a (
      .clock   (clock),
      .ctrl    (ctl_a),
      .a_bit   (a_a),
      .b_bit   (b_a),
      .sum_bit (sum_a),
      .carry   (carry_a)
   );

   ptc_bit_adder u_adder_b (
      .clock   (clock),
      .ctrl    (ctl_b),
      .a_bit   (a_b),
      .b_bit   (b_b),
      .sum_bit (sum_b),
      .carry   (carry_b)
   );

   // catch-up remainder of the overshoot by the interval
   ptc_remainder u_remainder (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dt_ff),
      .divisor   (interval_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // csr decode and the due time of a fresh arming
   always_comb begin
      csr_write    = csr_valid & csr_ready;
      csr_hit      = csr_write &&
                     (csr_index inside {CSR_INTERVAL, CSR_DELAY, CSR_REPEAT, CSR_FOREVER});
      interval_new = (csr_write && csr_index == CSR_INTERVAL) ? csr_data : interval_ff;
      delay_new    = (csr_write && csr_index == CSR_DELAY) ? csr_data : delay_ff;
      arm_due      = TIME_BITS'((delay_new != '0) ? delay_new : interval_new);
      pass_last    = (cnt_ff == CNT_LAST);
   end

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      interval_in  = interval_new;
      delay_in     = delay_new;
      repeat_in    = (csr_write && csr_index == CSR_REPEAT) ? csr_data : repeat_ff;
      forever_in   = (csr_write && csr_index == CSR_FOREVER) ? csr_data[0] : forever_ff;
      rt_in        = rt_ff;
      nd_in        = nd_ff;
      lf_in        = lf_ff;
      dt_in        = dt_ff;
      since_in     = since_ff;
      tick_in      = tick_ff;
      rsub_in      = rsub_ff;
      iv_in        = iv_ff;
      fc_in        = fc_ff;
      active_in    = active_ff;
      fired_in     = fired_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_fired_in = rsp_fired_ff;
      rsp_since_in = rsp_since_ff;
      rsp_armed_in = rsp_armed_ff;
      ctl_a        = '0;
      ctl_b        = '0;
      a_a          = rt_ff[0];
      b_a          = 1'b0;
      a_b          = rt_ff[0];
      b_b          = 1'b0;
      div_start    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               tick_in          = req_tick_ms;
               cnt_in           = '0;
               ctl_a.clear      = 1'b1;
               ctl_a.init_carry = 1'b0;
               state_in         = S_ADD;
            end
         end
         // running time plus tick, lsb first
         S_ADD: begin
            ctl_a.enable = 1'b1;
            b_a          = tick_ff[0];
            rt_in        = {sum_a, rt_ff[TIME_BITS-1:1]};
            tick_in      = {1'b0, tick_ff[TICK_BITS-1:1]};
            cnt_in       = cnt_ff + CNT_BITS'(1);
            if (pass_last) begin
               cnt_in   = '0;
               state_in = S_ADD_END;
            end
         end
         S_ADD_END: begin
            if (carry_a) begin
               rt_in = TIME_MAX;
            end
            ctl_a.clear      = 1'b1;
            ctl_a.init_carry = 1'b1;
            ctl_b.clear      = 1'b1;
            ctl_b.init_carry = 1'b1;
            state_in         = S_CMP;
         end
         // overshoot past due time and time since last fire
         S_CMP: begin
            ctl_a.enable   = 1'b1;
            ctl_a.invert_b = 1'b1;
            ctl_b.enable   = 1'b1;
            ctl_b.invert_b = 1'b1;
            b_a            = nd_ff[0];
            b_b            = lf_ff[0];
            rt_in          = {rt_ff[0], rt_ff[TIME_BITS-1:1]};
            nd_in          = {nd_ff[0], nd_ff[TIME_BITS-1:1]};
            lf_in          = {lf_ff[0], lf_ff[TIME_BITS-1:1]};
            dt_in          = {sum_a, dt_ff[TIME_BITS-1:1]};
            since_in       = {sum_b, since_ff[TIME_BITS-1:1]};
            cnt_in         = cnt_ff + CNT_BITS'(1);
            if (pass_last) begin
               cnt_in   = '0;
               state_in = S_CMP_END;
            end
         end
         // no borrow means running time has reached the due time
         S_CMP_END: begin
            if (active_ff && carry_a) begin
               fired_in = 1'b1;
               lf_in    = rt_ff;
               state_in = S_COUNT;
            end else begin
               fired_in = 1'b0;
               state_in = S_DONE;
            end
         end
         S_COUNT: begin
            if (fc_ff != COUNT_MAX) begin
               fc_in = fc_ff + REG_BITS'(1);
            end
            state_in = S_COUNT2;
         end
         S_COUNT2: begin
            if (!forever_ff) begin
               active_in = (fc_ff < repeat_ff);
            end
            if (interval_ff == '0) begin
               nd_in    = rt_ff;
               state_in = S_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               rsub_in          = div_rem;
               iv_in            = interval_ff;
               cnt_in           = '0;
               ctl_a.clear      = 1'b1;
               ctl_a.init_carry = 1'b1;
               ctl_b.clear      = 1'b1;
               ctl_b.init_carry = 1'b0;
               state_in         = S_UPD;
            end
         end
         // next due = (running time - remainder) + interval
         S_UPD: begin
            ctl_a.enable   = 1'b1;
            ctl_a.invert_b = 1'b1;
            ctl_b.enable   = 1'b1;
            b_a            = rsub_ff[0];
            a_b            = sum_a;
            b_b            = iv_ff[0];
            nd_in          = {sum_b, nd_ff[TIME_BITS-1:1]};
            rt_in          = {rt_ff[0], rt_ff[TIME_BITS-1:1]};
            rsub_in        = {1'b0, rsub_ff[REG_BITS-1:1]};
            iv_in          = {1'b0, iv_ff[REG_BITS-1:1]};
            cnt_in         = cnt_ff + CNT_BITS'(1);
            if (pass_last) begin
               cnt_in   = '0;
               state_in = S_UPD_END;
            end
         end
         S_UPD_END: begin
            if (carry_b) begin
               nd_in = TIME_MAX;
            end
            state_in = S_DONE;
         end
         // hand the response to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_fired_in = fired_ff;
               rsp_since_in = fired_ff ? OUT_BITS'(since_ff) : '0;
               rsp_armed_in = active_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a known register write re-arms the timer
      if (csr_hit) begin
         rt_in     = '0;
         nd_in     = arm_due;
         lf_in     = '0;
         fc_in     = '0;
         active_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         interval_ff  <= '0;
         delay_ff     <= '0;
         repeat_ff    <= '0;
         forever_ff   <= 1'b1;
         rt_ff        <= '0;
         nd_ff        <= '0;
         lf_ff        <= '0;
         fc_ff        <= '0;
         active_ff    <= 1'b1;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         interval_ff  <= interval_in;
         delay_ff     <= delay_in;
         repeat_ff    <= repeat_in;
         forever_ff   <= forever_in;
         rt_ff        <= rt_in;
         nd_ff        <= nd_in;
         lf_ff        <= lf_in;
         fc_ff        <= fc_in;
         active_ff    <= active_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dt_ff        <= dt_in;
      since_ff     <= since_in;
      tick_ff      <= tick_in;
      rsub_ff      <= rsub_in;
      iv_ff        <= iv_in;
      fired_ff     <= fired_in;
      rsp_fired_ff <= rsp_fired_in;
      rsp_since_ff <= rsp_since_in;
      rsp_armed_ff <= rsp_armed_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fired         = rsp_fired_ff;
   assign rsp_since_last_ms = rsp_since_ff;
   assign rsp_armed         = rsp_armed_ff;

   // a disarmed timer stays disarmed until re-armed by a csr write
   `PTC_ASSERT(a_disarm_sticky, clock, reset, !active_ff && !(csr_valid && csr_ready) |=> !active_ff, "timer re-armed without a csr write")
   // a response that did not fire carries no elapsed time
   `PTC_ASSERT(a_quiet_since, clock, reset, rsp_valid_ff && !rsp_fired_ff |-> rsp_since_ff == '0, "unfired response with nonzero since")
   // catch-up update only runs with a nonzero interval and a reduced remainder
   `PTC_ASSERT(a_upd_rem, clock, reset, state_ff == S_UPD |-> interval_ff != '0 && rsub_ff < interval_ff, "catch-up remainder not below interval")
   // a finished result held back by the rsp side stays in place
   `PTC_ASSERT(a_done_hold, clock, reset, state_ff == S_DONE && rsp_valid_ff && !rsp_ready |=> state_ff == S_DONE, "result dropped while output stalled")
endmodule
`default_nettype wire

// ===== hdl/ptc_bit_adder.sv =====
// one-bit serial adder/subtractor with a registered carry
`default_nettype none
module ptc_bit_adder (
   input  logic                    clock,
   input  ptc_pkg::adder_ctrl_type ctrl,
   input  logic                    a_bit,
   input  logic                    b_bit,
   output logic                    sum_bit,
   output logic                    carry
);
   import ptc_pkg::*;

   logic carry_ff;
   logic carry_in;
   logic b_eff;

   // sum of this bit, subtract by inverting b with carry preset
   always_comb begin
      b_eff   = b_bit ^ ctrl.invert_b;
      sum_bit = a_bit ^ b_eff ^ carry_ff;
      if (ctrl.clear) begin
         carry_in = ctrl.init_carry;
      end else if (ctrl.enable) begin
         carry_in = (a_bit & b_eff) | (a_bit & carry_ff) | (b_eff & carry_ff);
      end else begin
         carry_in = carry_ff;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
   end

   assign carry = carry_ff;
endmodule
`default_nettype wire

// ===== hdl/ptc_remainder.sv =====
// restoring remainder unit, one dividend bit per cycle
`default_nettype none
module ptc_remainder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ptc_pkg::TIME_BITS-1:0]   dividend,
   input  logic [ptc_pkg::REG_BITS-1:0]    divisor,
   output logic                            done,
   output logic [ptc_pkg::REG_BITS-1:0]    remainder
);
   import ptc_pkg::*;

   logic [TIME_BITS-1:0] quo_ff, quo_in;
   logic [REG_BITS-1:0]  rem_ff, rem_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [REG_BITS:0]    trial;
   logic [REG_BITS:0]    diff;

   // trial subtract of the divisor from the shifted partial remainder
   always_comb begin
      trial   = {rem_ff, quo_ff[TIME_BITS-1]};
      diff    = trial - {1'b0, divisor};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[TIME_BITS-2:0], 1'b0};
         rem_in = diff[REG_BITS] ? trial[REG_BITS-1:0] : diff[REG_BITS-1:0];
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

// ===== tb/periodic_timer_catchup_top_tb.sv =====
// self-checking testbench for the periodic timer: directed ticks, random phases, backpressure
module periodic_timer_catchup_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ptc_pkg::*;

   localparam int HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = 250;
   localparam logic [IDX_BITS-1:0] CSR_UNUSED_LOW = CSR_FOREVER + IDX_BITS'(1);
   localparam logic [IDX_BITS-1:0] CSR_UNUSED_TOP = '1;

   typedef struct packed {
      logic                fired;
      logic [OUT_BITS-1:0] since_ms;
      logic                armed;
   } tick_outcome_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [TICK_BITS-1:0] req_tick_ms = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_fired;
   logic [OUT_BITS-1:0]  rsp_since_last_ms;
   logic                 rsp_armed;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [IDX_BITS-1:0]  csr_index = '0;
   logic [REG_BITS-1:0]  csr_data = '0;

   // timer registers and state as the block should hold them
   logic [REG_BITS-1:0]  c_interval;
   logic [REG_BITS-1:0]  c_delay;
   logic [REG_BITS-1:0]  c_repeat;
   logic                 c_forever;
   logic [TIME_BITS-1:0] t_run_ms;
   logic [TIME_BITS-1:0] t_due_ms;
   logic [TIME_BITS-1:0] t_last_fire_ms;
   logic [REG_BITS-1:0]  t_fires;
   logic                 t_armed;

   tick_outcome_type outcome_q[$];
   int            errors = 0;
   logic          calm = 1'b0;
   int            hold_orders = 0;
   int            hold_taken = 0;
   int            stall_left = 0;

   periodic_timer_catchup_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_tick_ms(req_tick_ms),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_fired(rsp_fired),
      .rsp_since_last_ms(rsp_since_last_ms),
      .rsp_armed(rsp_armed),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // re-arm with the current register values
   function automatic void rearm_timer();
      t_run_ms = '0;
      t_due_ms = (c_delay != 0) ? TIME_BITS'(c_delay) : TIME_BITS'(c_interval);
      t_last_fire_ms = '0;
      t_fires = '0;
      t_armed = 1'b1;
   endfunction

   function automatic void load_register(input logic [IDX_BITS-1:0] idx,
                                         input logic [REG_BITS-1:0] val);
      case (idx)
         CSR_INTERVAL: c_interval = val;
         CSR_DELAY:    c_delay = val;
         CSR_REPEAT:   c_repeat = val;
         CSR_FOREVER:  c_forever = val[0];
         // unknown index: no write, no re-arm
         default: return;
      endcase
      rearm_timer();
   endfunction

   // one tick: add elapsed time, fire when due, skip missed periods
   function automatic tick_outcome_type advance_timer(input logic [TICK_BITS-1:0] t);
      logic [TIME_BITS:0]   sum;
      logic [TIME_BITS-1:0] late;
      logic [TIME_BITS-1:0] base;
      logic [TIME_BITS:0]   nxt;
      tick_outcome_type     res;
      res = '0;
      sum = {1'b0, t_run_ms} + t;
      t_run_ms = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
      if (t_armed && t_run_ms >= t_due_ms) begin
         res.fired = 1'b1;
         res.since_ms = OUT_BITS'(t_run_ms - t_last_fire_ms);
         t_last_fire_ms = t_run_ms;
         if (c_interval == 0) begin
            t_due_ms = t_run_ms;
         end else begin
            late = t_run_ms - t_due_ms;
            base = t_due_ms + (late - late % TIME_BITS'(c_interval));
            nxt = {1'b0, base} + c_interval;
            t_due_ms = nxt[TIME_BITS] ? TIME_MAX : nxt[TIME_BITS-1:0];
         end
         if (t_fires != COUNT_MAX) t_fires = t_fires + 1;
         if (!c_forever) t_armed = (t_fires < c_repeat);
      end
      res.armed = t_armed;
      return res;
   endfunction

   task automatic log_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
      $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
      errors++;
   endtask

   // response ready: rare short stalls, plus a long hold-off on demand
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (hold_taken != hold_orders) begin
         hold_taken <= hold_orders;
         stall_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(99) == 0) begin
         stall_left <= $urandom_range(16);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each accepted response with the oldest outstanding tick
   always @(posedge clock) begin : check_rsp
      tick_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (outcome_q.size() == 0) begin
            log_mismatch("response with no tick outstanding", rsp_fired, 0);
         end else begin
            want = outcome_q.pop_front();
            if (rsp_fired !== want.fired)
               log_mismatch("fired", rsp_fired, want.fired);
            if (rsp_since_last_ms !== want.since_ms)
               log_mismatch("since_last_ms", rsp_since_last_ms, want.since_ms);
            if (rsp_armed !== want.armed)
               log_mismatch("armed", rsp_armed, want.armed);
         end
      end
   end

   task automatic send_tick(input logic [TICK_BITS-1:0] t);
      req_valid <= 1'b1;
      req_tick_ms <= t;
      do @(posedge clock); while (!req_ready);
      outcome_q.insert(outcome_q.size(), advance_timer(t));
      if (!calm && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 100)) @(posedge clock);
      end
   endtask

   // drop the request line and wait until every tick has answered
   task automatic settle();
      req_valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [REG_BITS-1:0] val,
                            input logic last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      load_register(idx, val);
      if (last) csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [REG_BITS-1:0] ivl, input logic [REG_BITS-1:0] dly,
                            input logic [REG_BITS-1:0] rep, input logic keep);
      logic [REG_BITS-1:0] junk;
      junk = $urandom();
      write_reg(CSR_INTERVAL, ivl, 1'b0);
      write_reg(CSR_DELAY, dly, 1'b0);
      write_reg(CSR_REPEAT, rep, 1'b0);
      // upper bits of the flag register carry noise
      write_reg(CSR_FOREVER, {junk[REG_BITS-1:1], keep}, 1'b1);
   endtask

   function automatic logic [REG_BITS-1:0] pick_span();
      case ($urandom_range(5))
         0: return '0;
         1: return REG_BITS'(1);
         2: return REG_BITS'($urandom_range(2, 200));
         3: return REG_BITS'($urandom_range(1000, 70000));
         4: return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [REG_BITS-1:0] pick_repeat();
      case ($urandom_range(4))
         0: return '0;
         1: return REG_BITS'(1);
         2: return REG_BITS'($urandom_range(2, 20));
         3: return '1;
         default: return $urandom();
      endcase
   endfunction

   // mostly ticks near the interval, some zero, some over the full range
   function automatic logic [TICK_BITS-1:0] random_tick(input logic [REG_BITS-1:0] ivl);
      int unsigned     r;
      longint unsigned top;
      r = $urandom_range(99);
      top = 2 * longint'(ivl) + 1;
      if (top > 65535) top = 65535;
      if (r < 10) return '0;
      if (r < 22) return TICK_BITS'($urandom());
      return TICK_BITS'($urandom_range(int'(top), 0));
   endfunction

   // reset values: zero interval and delay, fires on every tick
   task automatic test_power_on_defaults();
      send_tick('0);
      send_tick('1);
      send_tick(TICK_BITS'(16'h5555));
      settle();
   endtask

   // delay to first fire, then interval, then a catch-up over missed periods
   task automatic test_delay_and_catchup();
      configure(32'd10, 32'd25, '0, 1'b1);
      send_tick(TICK_BITS'(10));
      send_tick(TICK_BITS'(10));
      send_tick(TICK_BITS'(5));
      send_tick(TICK_BITS'(3));
      send_tick(TICK_BITS'(7));
      send_tick(TICK_BITS'(100));
      settle();
   endtask

   // disarm after the repeat count, and the single fire of a zero count
   task automatic test_repeat_disarm();
      configure(32'd5, '0, 32'd2, 1'b0);
      repeat (4) send_tick(TICK_BITS'(5));
      settle();
      configure('0, '0, '0, 1'b0);
      send_tick(TICK_BITS'(1));
      send_tick('0);
      settle();
   endtask

   // all-ones registers and the smallest nonzero delay
   task automatic test_wide_registers();
      configure('1, '1, '1, 1'b0);
      send_tick('1);
      send_tick('1);
      settle();
      configure('1, REG_BITS'(1), '1, 1'b1);
      send_tick(TICK_BITS'(1));
      send_tick(TICK_BITS'(16'hAAAA));
      settle();
   endtask

   // writes to unknown indexes must neither change a register nor re-arm
   task automatic test_unused_index();
      configure(32'd7, '0, '0, 1'b1);
      send_tick(TICK_BITS'(5));
      settle();
      write_reg(CSR_UNUSED_LOW, '0, 1'b0);
      write_reg(CSR_UNUSED_TOP, '1, 1'b1);
      send_tick(TICK_BITS'(2));
      send_tick(TICK_BITS'(9));
      settle();
   endtask

   // random settings with ticks shaped around each interval
   task automatic test_random_phases();
      logic [REG_BITS-1:0] ivl;
      logic [REG_BITS-1:0] dly;
      logic [REG_BITS-1:0] rep;
      for (int p = 0; p < 8; p++) begin
         ivl = pick_span();
         dly = ($urandom_range(1) == 0) ? '0 : pick_span();
         rep = pick_repeat();
         // one phase runs with no idling on either side
         calm <= (p == 3);
         configure(ivl, dly, rep, $urandom_range(9) < 7);
         for (int n = 0; n < 60; n++) send_tick(random_tick(ivl));
         settle();
      end
      calm <= 1'b0;
   endtask

   // long response hold-off while ticks keep coming, so the input stalls
   task automatic test_output_backpressure();
      configure(32'd3, '0, '0, 1'b1);
      hold_orders <= hold_orders + 1;
      for (int n = 0; n < 40; n++) send_tick(TICK_BITS'($urandom_range(8)));
      settle();
   endtask

   initial begin
      c_interval = '0;
      c_delay = '0;
      c_repeat = '0;
      c_forever = 1'b1;
      rearm_timer();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_power_on_defaults();
      test_delay_and_catchup();
      test_repeat_disarm();
      test_wide_registers();
      test_unused_index();
      test_random_phases();
      test_output_backpressure();
      // catch any late or spurious response
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // run limit
   initial begin
      #10ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ptc_pkg.sv
hdl/ptc_bit_adder.sv
hdl/ptc_remainder.sv
hdl/periodic_timer_catchup_top.sv
tb/periodic_timer_catchup_top_tb.sv
